// ----- src/amplitude_to_db_normalizer_macros.svh -----
// Assertion helpers shared by the normalizer RTL.
`ifndef AMPLITUDE_TO_DB_NORMALIZER_MACROS_SVH
`define AMPLITUDE_TO_DB_NORMALIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ATDB_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ATDB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/atdb_pkg.sv -----
package atdb_pkg;

    localparam int MAG_W       = 24;
    localparam int FLOOR_W     = 8;
    localparam int LOG_FRAC    = 16;
    localparam int POS_W       = $clog2(MAG_W);
    localparam int LOG_W       = POS_W + LOG_FRAC;
    localparam int FQ_W        = FLOOR_W + LOG_FRAC;
    localparam int DB_W        = 19;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // 20*log10(2) in Q.16
    localparam logic [DB_W-1:0]    DB_PER_OCTAVE = 19'd394566;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET   = 8'd80;

    typedef enum logic [1:0] {
        FUNC_CLEAR   = 2'd0,
        FUNC_MEASURE = 2'd1,
        FUNC_CONVERT = 2'd2
    } t_func;

    // One convert request with the reference it must be scored against
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] ref_mag;
    } t_job;

endpackage

// ----- src/atdb_log2.sv -----
module atdb_log2 #(
    parameter int LOG_TABLE_ENTRIES = 64
) (
    input  logic [atdb_pkg::MAG_W-1:0] i_value,
    output logic [atdb_pkg::LOG_W-1:0] o_log
);

    localparam int IDX_W  = (LOG_TABLE_ENTRIES > 1) ? $clog2(LOG_TABLE_ENTRIES) : 1;
    localparam int PROD_W = 31 + IDX_W;

    // floor(log2(1 + i/N) * 2^16) by repeated squaring in Q30
    function automatic logic [atdb_pkg::LOG_FRAC-1:0] mant_entry(input int unsigned i);
        longint unsigned y;
        logic [atdb_pkg::LOG_FRAC-1:0] acc;
        y   = ((longint'(LOG_TABLE_ENTRIES) + longint'(i)) << 30) / LOG_TABLE_ENTRIES;
        acc = '0;
        for (int k = 0; k < atdb_pkg::LOG_FRAC; k++) begin
            y   = (y * y) >> 30;
            acc = {acc[atdb_pkg::LOG_FRAC-2:0], 1'b0};
            if (y >= (64'd2 << 30)) begin
                y      = y >> 1;
                acc[0] = 1'b1;
            end
        end
        return acc;
    endfunction

    logic [atdb_pkg::LOG_FRAC-1:0] w_table [LOG_TABLE_ENTRIES];
    logic [atdb_pkg::MAG_W-1:0]    w_val;
    logic [atdb_pkg::POS_W-1:0]    w_pos;
    logic [5:0]                    w_sh;
    logic [31:0]                   w_norm;
    logic [PROD_W-1:0]             w_prod;
    logic [IDX_W-1:0]              w_idx;

    for (genvar g = 0; g < LOG_TABLE_ENTRIES; g++) begin : g_tab
        assign w_table[g] = mant_entry(g);
    end

    always_comb begin
        // zero counts as one LSB
        w_val = (i_value == '0) ? atdb_pkg::MAG_W'(1) : i_value;
        w_pos = '0;
        for (int b = 0; b < atdb_pkg::MAG_W; b++) begin
            if (w_val[b]) begin
                w_pos = atdb_pkg::POS_W'(b);
            end
        end
    end

    assign w_sh   = 6'd31 - 6'(w_pos);
    assign w_norm = 32'(w_val) << w_sh;
    assign w_prod = PROD_W'(w_norm[30:0]) * PROD_W'(LOG_TABLE_ENTRIES);
    assign w_idx  = w_prod[PROD_W-1:31];
    assign o_log  = {w_pos, w_table[w_idx]};

endmodule

// ----- src/atdb_front.sv -----
`include "amplitude_to_db_normalizer_macros.svh"

module atdb_front #(
    parameter int MAG_BITS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic [1:0]                 i_func,
    input  logic [atdb_pkg::MAG_W-1:0] i_magnitude,
    output logic                       o_job_wr,
    output atdb_pkg::t_job             o_job,
    input  logic                       i_job_full
);

    localparam int USE_BITS = (MAG_BITS < atdb_pkg::MAG_W) ? MAG_BITS : atdb_pkg::MAG_W;
    localparam logic [atdb_pkg::MAG_W-1:0] MAG_MASK =
        atdb_pkg::MAG_W'((64'd1 << USE_BITS) - 64'd1);

    logic [atdb_pkg::MAG_W-1:0] r_ref;
    logic [atdb_pkg::MAG_W-1:0] w_mag;
    logic                       w_accept;

    assign o_full   = i_job_full;
    assign w_accept = i_push && !i_job_full;
    assign w_mag    = i_magnitude & MAG_MASK;

    always_comb begin
        o_job_wr = 1'b0;
        if (w_accept && (i_func == atdb_pkg::FUNC_CONVERT)) begin
            o_job_wr = 1'b1;
        end
    end

    // snapshot the reference as it stands when the convert request arrives
    assign o_job.mag     = w_mag;
    assign o_job.ref_mag = r_ref;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= '0;
        end else if (w_accept) begin
            case (atdb_pkg::t_func'(i_func))
                atdb_pkg::FUNC_CLEAR: begin
                    r_ref <= '0;
                end
                atdb_pkg::FUNC_MEASURE: begin
                    if (w_mag > r_ref) begin
                        r_ref <= w_mag;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `ATDB_ASSERT_NEXT(a_measure_never_lowers, i_clk, i_rst_n, w_accept && (i_func == atdb_pkg::FUNC_MEASURE), r_ref >= $past(r_ref), "measure lowered the reference")

endmodule

// ----- src/atdb_queue.sv -----
`include "amplitude_to_db_normalizer_macros.svh"

module atdb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  atdb_pkg::t_job i_wdata,
    output logic           o_full,
    input  logic           i_rd,
    output atdb_pkg::t_job o_rdata,
    output logic           o_empty
);

    atdb_pkg::t_job                r_mem [atdb_pkg::QUEUE_DEPTH];
    logic [atdb_pkg::QPTR_W-1:0]   r_wptr;
    logic [atdb_pkg::QPTR_W-1:0]   r_rptr;
    logic [atdb_pkg::QPTR_W:0]     r_count;

    assign o_full  = (r_count == (atdb_pkg::QPTR_W+1)'(atdb_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ATDB_ASSERT_NEXT(a_fill_tracks_writes, i_clk, i_rst_n, i_wr && !i_rd, r_count == $past(r_count) + 1'b1, "queue fill count lost a write")

endmodule

// ----- src/atdb_back.sv -----
`include "amplitude_to_db_normalizer_macros.svh"

module atdb_back #(
    parameter int OUT_FRAC_BITS     = 16,
    parameter int LOG_TABLE_ENTRIES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [atdb_pkg::FLOOR_W-1:0] i_cfg_wdata,
    input  atdb_pkg::t_job               i_job,
    input  logic                         i_job_empty,
    output logic                         o_job_rd,
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic [OUT_FRAC_BITS:0]       o_feature
);

    localparam int OUT_W  = OUT_FRAC_BITS + 1;
    localparam int CNT_W  = $clog2(OUT_FRAC_BITS);
    localparam int PROD_W = atdb_pkg::LOG_W + atdb_pkg::DB_W;
    localparam int ATT_W  = PROD_W - atdb_pkg::LOG_FRAC;
    localparam int CMP_W  = (ATT_W > atdb_pkg::FQ_W) ? ATT_W : atdb_pkg::FQ_W;
    localparam logic [OUT_W-1:0] ONE      = OUT_W'(1) << OUT_FRAC_BITS;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OUT_FRAC_BITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOG,
        ST_SCALE,
        ST_CMP,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state                       r_state;
    logic [atdb_pkg::FLOOR_W-1:0] r_floor;
    logic [atdb_pkg::MAG_W-1:0]   r_mag;
    logic [atdb_pkg::MAG_W-1:0]   r_ref;
    logic                         r_pos;
    logic [atdb_pkg::LOG_W-1:0]   r_diff;
    logic [ATT_W-1:0]             r_att;
    logic [atdb_pkg::FQ_W-1:0]    r_rem;
    logic [OUT_W-1:0]             r_quo;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_out_vld;
    logic [OUT_W-1:0]             r_out;

    logic [atdb_pkg::LOG_W-1:0]   w_lv;
    logic [atdb_pkg::LOG_W-1:0]   w_lr;
    logic [atdb_pkg::FQ_W-1:0]    w_fq;
    logic [PROD_W-1:0]            w_prod;
    logic [atdb_pkg::FQ_W:0]      w_rem2;
    logic                         w_ge;
    logic                         w_out_free;
    logic                         w_out_load;
    logic                         w_div_last;

    atdb_log2 #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_log_mag (
        .i_value (r_mag),
        .o_log   (w_lv)
    );

    atdb_log2 #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_log_ref (
        .i_value (r_ref),
        .o_log   (w_lr)
    );

    assign w_fq       = {r_floor, {atdb_pkg::LOG_FRAC{1'b0}}};
    // attenuation in dB, Q.16, rounded
    assign w_prod     = PROD_W'(r_diff) * PROD_W'(atdb_pkg::DB_PER_OCTAVE)
                        + PROD_W'(32'd32768);
    assign w_rem2     = {r_rem, 1'b0};
    assign w_ge       = (w_rem2 >= {1'b0, w_fq});
    assign w_out_free = !r_out_vld || i_pop;
    assign w_out_load = (r_state == ST_DONE) && w_out_free;
    assign w_div_last = (r_state == ST_DIV) && (r_cnt == CNT_LAST);
    assign o_job_rd   = (r_state == ST_IDLE) && !i_job_empty;
    assign o_empty    = !r_out_vld;
    assign o_feature  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_floor   <= atdb_pkg::FLOOR_RESET;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_floor <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_pop) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_job_empty) begin
                        r_mag   <= i_job.mag;
                        r_ref   <= i_job.ref_mag;
                        r_state <= ST_LOG;
                    end
                end
                ST_LOG: begin
                    r_pos   <= (w_lv >= w_lr);
                    r_diff  <= w_lr - w_lv;
                    r_state <= ST_SCALE;
                end
                ST_SCALE: begin
                    r_att   <= w_prod[PROD_W-1:atdb_pkg::LOG_FRAC];
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    r_cnt <= '0;
                    if (r_pos) begin
                        r_quo   <= ONE;
                        r_state <= ST_DONE;
                    end else if ((w_fq == '0) || (CMP_W'(r_att) >= CMP_W'(w_fq))) begin
                        r_quo   <= '0;
                        r_state <= ST_DONE;
                    end else begin
                        // att < fq here, so the difference fits
                        r_rem   <= w_fq - atdb_pkg::FQ_W'(r_att);
                        r_quo   <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // restoring division, one quotient bit per cycle
                    if (w_ge) begin
                        r_rem <= atdb_pkg::FQ_W'(w_rem2 - {1'b0, w_fq});
                    end else begin
                        r_rem <= w_rem2[atdb_pkg::FQ_W-1:0];
                    end
                    r_quo <= {r_quo[OUT_W-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hold until the output register has room
                    if (w_out_free) begin
                        r_out   <= r_quo;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `ATDB_ASSERT(a_feature_in_range, i_clk, i_rst_n, r_out_vld, r_out <= ONE, "feature above 1.0")
    `ATDB_ASSERT_NEXT(a_div_ends, i_clk, i_rst_n, w_div_last, r_state == ST_DONE, "division overran")
    `ATDB_ASSERT_NEXT(a_pop_starts_job, i_clk, i_rst_n, o_job_rd, r_state == ST_LOG, "job not started")

endmodule

// ----- src/amplitude_to_db_normalizer.sv -----
// Normalized dB feature from linear spectral magnitudes, scored against a running maximum.
// Input channel: push/full with i_func and i_magnitude. Clear zeroes the reference,
// measure raises it to the magnitude, convert yields one feature; code 3 is dropped.
// Output channel: empty/pop with o_feature (Q1.OUT_FRAC_BITS, 1 << OUT_FRAC_BITS = 1.0).
// Config: i_cfg_we/i_cfg_wdata writes floor_db (dB range mapped to 0); write only when idle.
// Clear and measure requests are taken one per cycle unless full. Convert requests go
// into a four-entry queue; the back end scores one at a time: log2 lookup, dB scaling,
// compare, then a restoring divider yielding one quotient bit per cycle.
// A convert passes ST_LOG, ST_SCALE, ST_CMP, the divider and ST_DONE in the back end;
// a result that saturates to 0 or 1.0 skips the divider. A new convert leaves the queue
// only once the back end has handed the last result to the output register.
// full rises while the queue holds four pending converts; clear and measure wait too.
// If pop stays low, one result is held on the output and the back end waits with the
// next one finished; the queue keeps taking requests until it fills.
// Reset (synchronous, active low) empties the queue and the output, zeroes the
// reference and sets floor_db to 80.
module amplitude_to_db_normalizer #(
    parameter int MAG_BITS          = 24,
    parameter int OUT_FRAC_BITS     = 16,
    parameter int LOG_TABLE_ENTRIES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   i_func,
    input  logic [atdb_pkg::MAG_W-1:0]   i_magnitude,
    input  logic                         i_cfg_we,
    input  logic [atdb_pkg::FLOOR_W-1:0] i_cfg_wdata,
    output logic                         empty,
    input  logic                         pop,
    output logic [OUT_FRAC_BITS:0]       o_feature
);

    atdb_pkg::t_job w_wjob;
    atdb_pkg::t_job w_rjob;
    logic           w_job_wr;
    logic           w_job_full;
    logic           w_job_rd;
    logic           w_job_empty;

    atdb_front #(.MAG_BITS(MAG_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_func      (i_func),
        .i_magnitude (i_magnitude),
        .o_job_wr    (w_job_wr),
        .o_job       (w_wjob),
        .i_job_full  (w_job_full)
    );

    atdb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_job_wr),
        .i_wdata (w_wjob),
        .o_full  (w_job_full),
        .i_rd    (w_job_rd),
        .o_rdata (w_rjob),
        .o_empty (w_job_empty)
    );

    atdb_back #(
        .OUT_FRAC_BITS     (OUT_FRAC_BITS),
        .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_job       (w_rjob),
        .i_job_empty (w_job_empty),
        .o_job_rd    (w_job_rd),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_feature   (o_feature)
    );

endmodule

// ----- bench/testbench.sv -----
module testbench;

    localparam int          FEAT_W        = 17;
    localparam int          TABLE_N       = 64;
    localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
    // room for the back end to finish its longest convert; leave margin
    localparam int          SETTLE_CYCLES = 40;
    // ~700 requests, with room for receiver stalls and drains, taken several times
    localparam int          LIMIT_CYCLES  = 600000;

    class db_scoreboard;
        logic [FEAT_W-1:0]            expected_features[$];
        logic [atdb_pkg::MAG_W-1:0]   peak_mag;
        logic [atdb_pkg::FLOOR_W-1:0] floor_db;
        longint unsigned              mant_log2[TABLE_N];
        int                           mismatches;
        int                           checked;

        function new();
            longint unsigned y;
            longint unsigned acc;
            for (int i = 0; i < TABLE_N; i++) begin
                y   = ((64'(TABLE_N) + 64'(i)) << 30) / 64'(TABLE_N);
                acc = 0;
                // square in Q30, take one bit of the log per step
                for (int k = 0; k < atdb_pkg::LOG_FRAC; k++) begin
                    y   = (y * y) >> 30;
                    acc = acc << 1;
                    if (y >= (64'd2 << 30)) begin
                        y   = y >> 1;
                        acc = acc | 64'd1;
                    end
                end
                mant_log2[i] = acc;
            end
            peak_mag   = '0;
            floor_db   = atdb_pkg::FLOOR_RESET;
            mismatches = 0;
            checked    = 0;
        endfunction

        function longint unsigned log2_q16(logic [atdb_pkg::MAG_W-1:0] v);
            longint unsigned x;
            longint unsigned frac;
            longint unsigned idx;
            int              msb;
            // zero counts as one LSB
            x   = (v == 0) ? 64'd1 : 64'(v);
            msb = 0;
            for (int b = 0; b < 32; b++)
                if (x[b])
                    msb = b;
            frac = (x << (31 - msb)) & 64'h7FFF_FFFF;
            idx  = (frac * TABLE_N) >> 31;
            if (idx > TABLE_N - 1)
                idx = TABLE_N - 1;
            return (64'(msb) << atdb_pkg::LOG_FRAC) + mant_log2[idx];
        endfunction

        function logic [FEAT_W-1:0] score(logic [atdb_pkg::MAG_W-1:0] v);
            longint unsigned unity;
            longint unsigned lv;
            longint unsigned lr;
            longint unsigned att;
            longint unsigned fq;
            longint unsigned q;
            unity = 64'd1 << (FEAT_W - 1);
            lv    = log2_q16(v);
            lr    = log2_q16(peak_mag);
            if (lv >= lr)
                return unity[FEAT_W-1:0];
            att = ((lr - lv) * 64'(atdb_pkg::DB_PER_OCTAVE) + 64'd32768) >> 16;
            fq  = 64'(floor_db) << 16;
            if (att >= fq || fq == 0)
                return '0;
            q = ((fq - att) << (FEAT_W - 1)) / fq;
            if (q > unity)
                q = unity;
            return q[FEAT_W-1:0];
        endfunction

        function void note_request(logic [1:0] func, logic [atdb_pkg::MAG_W-1:0] mag);
            case (func)
                atdb_pkg::FUNC_CLEAR:   peak_mag = '0;
                atdb_pkg::FUNC_MEASURE: if (mag > peak_mag) peak_mag = mag;
                atdb_pkg::FUNC_CONVERT: expected_features.push_back(score(mag));
                default:                ;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task check_feature(logic [FEAT_W-1:0] got);
            logic [FEAT_W-1:0] want;
            if (expected_features.size() == 0) begin
                report_mismatch($sformatf("feature %0d with no convert pending", got));
            end else begin
                want = expected_features.pop_front();
                checked++;
                if (got !== want)
                    report_mismatch($sformatf("feature %0d, want %0d", got, want));
            end
        endtask
    endclass

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         push        = 1'b0;
    logic [1:0]                   i_func      = atdb_pkg::FUNC_CLEAR;
    logic [atdb_pkg::MAG_W-1:0]   i_magnitude = '0;
    logic                         i_cfg_we    = 1'b0;
    logic [atdb_pkg::FLOOR_W-1:0] i_cfg_wdata = '0;
    logic                         pop         = 1'b0;
    logic                         full;
    logic                         empty;
    logic [FEAT_W-1:0]            o_feature;

    db_scoreboard board;
    int           send_idle_pct = 6;
    int           recv_idle_pct = 74;
    int           hold_left     = 0;
    int           items_sent    = 0;
    int           cycle_count   = 0;
    logic [atdb_pkg::FLOOR_W-1:0] mid_floor;

    amplitude_to_db_normalizer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_func      (i_func),
        .i_magnitude (i_magnitude),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .empty       (empty),
        .pop         (pop),
        .o_feature   (o_feature)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random pop, with an occasional long hold-off counted here
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
            @(posedge i_clk);
            if (pop && !empty)
                board.check_feature(o_feature);
        end
    end

    function automatic logic [atdb_pkg::MAG_W-1:0] rand_mag();
        int          bits;
        logic [31:0] mask;
        // spread over bit lengths so every octave shows up
        bits = $urandom_range(0, atdb_pkg::MAG_W);
        mask = (32'd1 << bits) - 32'd1;
        return atdb_pkg::MAG_W'($urandom & mask);
    endfunction

    task automatic send_request(input logic [1:0] func,
                                input logic [atdb_pkg::MAG_W-1:0] mag);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push        <= 1'b1;
        i_func      <= func;
        i_magnitude <= mag;
        forever begin
            @(posedge i_clk);
            if (!full)
                break;
        end
        board.note_request(func, mag);
        if (func != FUNC_UNUSED)
            items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (board.expected_features.size() != 0)
            @(posedge i_clk);
        // clear and measure give no result; let the back end settle
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_floor(input logic [atdb_pkg::FLOOR_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        board.floor_db = value;
    endtask

    // Clips: clear, a few measures, then converts; some skip the clear or the
    // measures, and a few stray unused codes get mixed in.
    task automatic run_clips(input int target);
        int start;
        int n_meas;
        int n_conv;
        start = items_sent;
        while (items_sent - start < target) begin
            if ($urandom_range(0, 9) != 0)
                send_request(atdb_pkg::FUNC_CLEAR, rand_mag());
            n_meas = $urandom_range(0, 8);
            repeat (n_meas) send_request(atdb_pkg::FUNC_MEASURE, rand_mag());
            n_conv = $urandom_range(1, 12);
            repeat (n_conv) begin
                if ($urandom_range(0, 19) == 0)
                    send_request(FUNC_UNUSED, rand_mag());
                else
                    send_request(atdb_pkg::FUNC_CONVERT, rand_mag());
            end
        end
    endtask

    initial begin
        board = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero reference, full-scale reference, unused code, clear
        send_request(atdb_pkg::FUNC_CONVERT, 24'd0);
        send_request(atdb_pkg::FUNC_CONVERT, 24'hFFFFFF);
        send_request(atdb_pkg::FUNC_MEASURE, 24'hFFFFFF);
        send_request(atdb_pkg::FUNC_CONVERT, 24'd0);
        send_request(atdb_pkg::FUNC_CONVERT, 24'd1);
        send_request(atdb_pkg::FUNC_CONVERT, 24'h800000);
        send_request(atdb_pkg::FUNC_CONVERT, 24'h0FFFFF);
        send_request(atdb_pkg::FUNC_CONVERT, 24'hFFFFFF);
        send_request(FUNC_UNUSED,            24'hFFFFFF);
        send_request(atdb_pkg::FUNC_CONVERT, 24'h123456);
        send_request(atdb_pkg::FUNC_MEASURE, 24'd1);
        send_request(atdb_pkg::FUNC_CLEAR,   24'd0);
        send_request(atdb_pkg::FUNC_CONVERT, 24'd5);
        send_request(atdb_pkg::FUNC_MEASURE, 24'd0);
        send_request(atdb_pkg::FUNC_MEASURE, 24'd1000);
        send_request(atdb_pkg::FUNC_MEASURE, 24'd10);
        send_request(atdb_pkg::FUNC_CONVERT, 24'd10);
        send_request(atdb_pkg::FUNC_CONVERT, 24'd999);
        send_request(atdb_pkg::FUNC_CONVERT, 24'd2000);

        // Zero floor: hard step between 1.0 and 0
        write_floor(8'd0);
        send_request(atdb_pkg::FUNC_CONVERT, 24'd1000);
        send_request(atdb_pkg::FUNC_CONVERT, 24'd500);
        send_request(atdb_pkg::FUNC_CONVERT, 24'd0);

        mid_floor = atdb_pkg::FLOOR_W'($urandom_range(1, 144));
        write_floor(mid_floor);
        run_clips(200);

        send_idle_pct = 74;
        recv_idle_pct = 6;
        write_floor(8'd144);
        run_clips(200);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_floor(8'd1);
        // hold the receiver off so the queue fills and full stalls the sender
        hold_left = 300;
        repeat (16) send_request(atdb_pkg::FUNC_CONVERT, rand_mag());
        run_clips(200);

        wait_drained();
        $display("Sent %0d requests and checked %0d features.", items_sent, board.checked);
        $display("Floors used: 80, 0, %0d, 144 and 1; idling on each side and on neither.",
                 mid_floor);
        if (board.mismatches == 0 && board.expected_features.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+src
src/atdb_pkg.sv
src/atdb_log2.sv
src/atdb_front.sv
src/atdb_queue.sv
src/atdb_back.sv
src/amplitude_to_db_normalizer.sv
bench/testbench.sv
